// ----- rtl/column_summary_statistics_unit_assert.svh -----
// Assertion macros for the column summary statistics unit.
// Used by modules that have clk and rst_n in scope; no other dependencies.
`ifndef COLUMN_SUMMARY_STATISTICS_UNIT_ASSERT_SVH
`define COLUMN_SUMMARY_STATISTICS_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSU_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CSU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSU_ASSERT_IMPL(name, ante, cons, msg)
`define CSU_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- rtl/csu_pkg.sv -----
// Shared types and constants of the column summary statistics unit.
// No dependencies.
`default_nettype none
package csu_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 59;
  localparam int CNT_W    = 13;
  localparam int PROD_W   = 47;
  localparam int VAL_W    = 25;
  localparam int RAD_W    = 48;
  localparam int ROOT_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SDEV_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_EN = 2'd2;

  localparam logic [1:0] KIND_MEAN  = 2'd0;
  localparam logic [1:0] KIND_STDEV = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       column_end;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] stat_value;
    logic [1:0]              stat_kind;
    logic                    run_last;
  } out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]            sumsq;
    logic signed [SAMPLE_W-1:0] lowest;
    logic signed [SAMPLE_W-1:0] highest;
    logic [CNT_W-1:0]           count;
    logic                       mean_en;
    logic                       sdev_en;
    logic                       range_en;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// ----- rtl/column_summary_statistics_unit.sv -----
// Throughput: one sample per cycle while in_full is low; the back end handles one column at a
// time, running the bit-serial divider twice and then the square root.
// Two finished columns can wait in the job queue while samples keep flowing.
// Reset: rst_n synchronous, active low; enables set, totals cleared, queues emptied.
// Top level: front end, job queue and back end. Uses csu_pkg.
`default_nettype none
module column_summary_statistics_unit #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire csu_pkg::in_t                     in_data,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output csu_pkg::out_t                         out_data,
  input  wire logic                             cfg_we,
  input  wire logic [csu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csu_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic          jq_push, jq_full, jq_pop, jq_empty;
  csu_pkg::job_t jq_wdata, jq_rdata;

  csu_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .jq_push   (jq_push),
    .jq_data   (jq_wdata),
    .jq_full   (jq_full)
  );

  csu_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (jq_wdata),
    .full  (jq_full),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .empty (jq_empty)
  );

  csu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .jq_rdata  (jq_rdata),
    .jq_empty  (jq_empty),
    .jq_pop    (jq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/csu_front.sv -----
// Front end: takes samples, squares them and accumulates per-column totals.
// Holds the enable registers; hands a finished column to the job queue. Uses csu_pkg.
`default_nettype none
module csu_front #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire csu_pkg::in_t                     in_data,
  input  wire logic                             cfg_we,
  input  wire logic [csu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                  jq_push,
  output csu_pkg::job_t                         jq_data,
  input  wire logic                             jq_full
);

  localparam int CntW  = csu_pkg::CNT_W;
  localparam int SumW  = csu_pkg::SUM_W;
  localparam int SqW   = csu_pkg::SQ_W;
  localparam int SmpW  = csu_pkg::SAMPLE_W;
  localparam int ProdW = csu_pkg::PROD_W;
  localparam logic [CntW-1:0] MaxRowsC = CntW'(MAX_ROWS);

  logic mean_en_r, sdev_en_r, range_en_r;

  logic                   v_r, last_r;
  logic signed [SmpW-1:0] x_r;
  logic [ProdW-1:0]       sq_r;

  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic [SqW-1:0]         sumsq_r, sumsq_nxt;
  logic signed [SmpW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;

  logic                   stall, accept, step, take, first;
  logic signed [2*SmpW-1:0] prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_en_r  <= 1'b1;
      sdev_en_r  <= 1'b1;
      range_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csu_pkg::REG_MEAN_EN:  mean_en_r  <= cfg_wdata[0];
        csu_pkg::REG_SDEV_EN:  sdev_en_r  <= cfg_wdata[0];
        csu_pkg::REG_RANGE_EN: range_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign stall   = v_r & last_r & jq_full;
  assign accept  = in_push & ~stall;
  assign in_full = stall;
  assign step    = v_r & ~stall;
  assign prod    = in_data.sample * in_data.sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= 1'b0;
      last_r <= 1'b0;
    end else if (accept) begin
      v_r    <= 1'b1;
      last_r <= in_data.column_end;
    end else if (!stall) begin
      v_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r  <= in_data.sample;
      sq_r <= prod[ProdW-1:0];
    end
  end

  assign take  = (cnt_r != MaxRowsC);
  assign first = (cnt_r == '0);

  always_comb begin
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    if (step && take) begin
      sum_nxt   = sum_r + SumW'(x_r);
      sumsq_nxt = sumsq_r + SqW'(sq_r);
      cnt_nxt   = cnt_r + CntW'(1);
      lo_nxt    = (first || x_r < lo_r) ? x_r : lo_r;
      hi_nxt    = (first || x_r > hi_r) ? x_r : hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
    end else if (step && last_r) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
    end else begin
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign jq_push = step & last_r;

  always_comb begin
    jq_data.sum      = sum_nxt;
    jq_data.sumsq    = sumsq_nxt;
    jq_data.lowest   = lo_nxt;
    jq_data.highest  = hi_nxt;
    jq_data.count    = cnt_nxt;
    jq_data.mean_en  = mean_en_r;
    jq_data.sdev_en  = sdev_en_r;
    jq_data.range_en = range_en_r;
  end

endmodule
`default_nettype wire

// ----- rtl/csu_jobq.sv -----
// Two-entry queue of finished column totals between front and back end.
// Uses csu_pkg::job_t.
`default_nettype none
module csu_jobq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire csu_pkg::job_t wdata,
  output logic               full,
  input  wire logic          pop,
  output csu_pkg::job_t      rdata,
  output logic               empty
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  csu_pkg::job_t   mem_r [Depth];
  logic [PtrW-1:0] wptr_r, rptr_r;
  logic [CntW-1:0] cnt_r;

  assign full  = (cnt_r == CntW'(Depth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PtrW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PtrW'(1);
      end
      cnt_r <= cnt_r + CntW'(push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csu_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Unsigned dividend by unsigned count; zero divisor acts as one. Uses csu_pkg.
`default_nettype none
module csu_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [csu_pkg::SQ_W-1:0]    dividend,
  input  wire logic [csu_pkg::CNT_W-1:0]   divisor,
  output csu_pkg::unit_stat_t              stat,
  output logic [csu_pkg::SQ_W-1:0]         quot,
  output logic [csu_pkg::CNT_W-1:0]        rem
);

  localparam int DvdW  = csu_pkg::SQ_W;
  localparam int DenW  = csu_pkg::CNT_W;
  localparam int StepW = $clog2(DvdW);

  logic [DvdW-1:0]  dvd_r;
  logic [DenW-1:0]  den_r, rem_r;
  logic [StepW-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DenW:0]    sh;
  logic             ge;

  assign sh = {rem_r, dvd_r[DvdW-1]};
  assign ge = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= StepW'(DvdW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - StepW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      den_r <= (divisor == '0) ? DenW'(1) : divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DvdW-2:0], ge};
      rem_r <= ge ? DenW'(sh - {1'b0, den_r}) : sh[DenW-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dvd_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

// ----- rtl/csu_sqrt.sv -----
// Digit-by-digit floor square root, one root bit per cycle.
// Uses csu_pkg for widths and the status struct.
`default_nettype none
module csu_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [csu_pkg::RAD_W-1:0]    radicand,
  output csu_pkg::unit_stat_t               stat,
  output logic [csu_pkg::ROOT_W-1:0]        root
);

  localparam int RadW  = csu_pkg::RAD_W;
  localparam int RootW = csu_pkg::ROOT_W;
  localparam int RemW  = RootW + 2;
  localparam int StepW = $clog2(RootW);

  logic [RadW-1:0]  rad_r;
  logic [RemW-1:0]  rem_r;
  logic [RootW-1:0] root_r;
  logic [StepW-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [RemW+1:0]  sh, trial;
  logic             ge;

  assign sh    = {rem_r, rad_r[RadW-1:RadW-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = (sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= StepW'(RootW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - StepW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RadW-3:0], 2'b00};
      rem_r  <= ge ? RemW'(sh - trial) : RemW'(sh);
      root_r <= {root_r[RootW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule
`default_nettype wire

// ----- rtl/csu_back.sv -----
// Back end: per column computes mean, variance and its root, range, and
// queues the enabled results. Uses csu_pkg, csu_div, csu_sqrt and the assert macros.
`default_nettype none
`include "column_summary_statistics_unit_assert.svh"
module csu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire csu_pkg::job_t jq_rdata,
  input  wire logic          jq_empty,
  output logic               jq_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output csu_pkg::out_t      out_data
);

  localparam int SumW  = csu_pkg::SUM_W;
  localparam int SqW   = csu_pkg::SQ_W;
  localparam int SmpW  = csu_pkg::SAMPLE_W;
  localparam int ProdW = csu_pkg::PROD_W;
  localparam int ValW  = csu_pkg::VAL_W;
  localparam int RadW  = csu_pkg::RAD_W;
  localparam int RootW = csu_pkg::ROOT_W;
  localparam int CntW  = csu_pkg::CNT_W;
  localparam int ChkW  = 2 * RootW + 2;
  localparam int ODepth = 4;
  localparam int OPtrW  = $clog2(ODepth);
  localparam int OCntW  = $clog2(ODepth + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DSUM = 6'b000010,
    S_DSQ  = 6'b000100,
    S_VAR  = 6'b001000,
    S_SQRT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;

  csu_pkg::job_t          job_r;
  logic signed [SmpW-1:0] mean_r, mean_c;
  logic [ProdW-1:0]       msq_r, var_r, var_c;
  logic signed [ValW-1:0] range_r;

  csu_pkg::unit_stat_t div_stat, sqrt_stat;
  logic                div_start, sqrt_start, dsum_done;
  logic [SqW-1:0]      div_dividend, div_quot;
  logic [CntW-1:0]     div_divisor, div_rem;
  logic [RootW-1:0]    sqrt_root;
  logic [RootW:0]      root_up;
  logic [ChkW-1:0]     root_sq, root_up_sq;

  logic [SumW-1:0]        sum_bits, sum_mag;
  logic [SmpW:0]          m_mag, m_neg;
  logic signed [2*SmpW-1:0] msq_prod;
  logic [ProdW:0]         vdiff;

  logic                   en, is_last, ofull, opush, opop, advance;
  logic signed [ValW-1:0] val;
  csu_pkg::out_t          ow;

  csu_pkg::out_t   omem_r [ODepth];
  logic [OPtrW-1:0] owptr_r, orptr_r;
  logic [OCntW-1:0] ocnt_r;

  csu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  csu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (RadW'(var_c)),
    .stat     (sqrt_stat),
    .root     (sqrt_root)
  );

  assign sum_bits  = jq_rdata.sum;
  assign sum_mag   = sum_bits[SumW-1] ? (~sum_bits + SumW'(1)) : sum_bits;
  assign jq_pop    = (state_r == S_IDLE) && !jq_empty;
  assign dsum_done = (state_r == S_DSUM) && div_stat.done;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = SqW'(sum_mag);
    div_divisor  = jq_rdata.count;
    if (jq_pop) begin
      div_start = 1'b1;
    end else if (dsum_done) begin
      div_start    = 1'b1;
      div_dividend = job_r.sumsq;
      div_divisor  = job_r.count;
    end
  end

  // floor division of a negative sum rounds the magnitude up
  assign m_mag  = div_quot[SmpW:0] + (SmpW + 1)'(div_rem != '0);
  assign m_neg  = ~m_mag + (SmpW + 1)'(1);
  assign mean_c = job_r.sum[SumW-1] ? m_neg[SmpW-1:0] : div_quot[SmpW-1:0];

  assign msq_prod = mean_r * mean_r;
  assign vdiff    = {1'b0, div_quot[ProdW-1:0]} - {1'b0, msq_r};
  assign var_c    = vdiff[ProdW] ? '0 : vdiff[ProdW-1:0];
  assign sqrt_start = (state_r == S_VAR);

  assign root_up    = {1'b0, sqrt_root} + (RootW + 1)'(1);
  assign root_sq    = ChkW'(sqrt_root * sqrt_root);
  assign root_up_sq = ChkW'(root_up * root_up);

  always_comb begin
    case (kind_r)
      csu_pkg::KIND_MEAN: begin
        en      = job_r.mean_en;
        val     = ValW'(mean_r);
        is_last = !job_r.sdev_en && !job_r.range_en;
      end
      csu_pkg::KIND_STDEV: begin
        en      = job_r.sdev_en;
        val     = ValW'({1'b0, sqrt_root});
        is_last = !job_r.range_en;
      end
      default: begin
        en      = job_r.range_en;
        val     = range_r;
        is_last = 1'b1;
      end
    endcase
  end

  assign ofull   = (ocnt_r == OCntW'(ODepth));
  assign opush   = (state_r == S_EMIT) && en && !ofull;
  assign advance = (state_r == S_EMIT) && (!en || !ofull);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    unique case (state_r)
      S_IDLE: if (!jq_empty) state_nxt = S_DSUM;
      S_DSUM: if (div_stat.done) state_nxt = S_DSQ;
      S_DSQ:  if (div_stat.done) state_nxt = S_VAR;
      S_VAR:  state_nxt = S_SQRT;
      S_SQRT: begin
        if (sqrt_stat.done) begin
          state_nxt = S_EMIT;
          kind_nxt  = csu_pkg::KIND_MEAN;
        end
      end
      S_EMIT: begin
        if (advance) begin
          unique case (kind_r)
            csu_pkg::KIND_MEAN:  kind_nxt = csu_pkg::KIND_STDEV;
            csu_pkg::KIND_STDEV: kind_nxt = csu_pkg::KIND_RANGE;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= csu_pkg::KIND_MEAN;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msq_r <= msq_prod[ProdW-1:0];
    if (jq_pop) begin
      job_r   <= jq_rdata;
      range_r <= ValW'(jq_rdata.highest) - ValW'(jq_rdata.lowest);
    end
    if (dsum_done) begin
      mean_r <= mean_c;
    end
    if (sqrt_start) begin
      var_r <= var_c;
    end
  end

  always_comb begin
    ow.stat_value = val;
    ow.stat_kind  = kind_r;
    ow.run_last   = is_last;
  end

  assign opop      = out_pop && (ocnt_r != '0);
  assign out_empty = (ocnt_r == '0);
  assign out_data  = omem_r[orptr_r];

  always_ff @(posedge clk) begin
    if (opush) begin
      omem_r[owptr_r] <= ow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (opush) begin
        owptr_r <= owptr_r + OPtrW'(1);
      end
      if (opop) begin
        orptr_r <= orptr_r + OPtrW'(1);
      end
      ocnt_r <= ocnt_r + OCntW'(opush) - OCntW'(opop);
    end
  end

  `CSU_ASSERT_IMPL(a_ofifo_room, opush, ocnt_r != OCntW'(ODepth), "result pushed into full queue")
  `CSU_ASSERT_IMPL(a_mean_fits, dsum_done, div_quot[SqW-1:SmpW+1] == '0, "mean out of range")
  `CSU_ASSERT_IMPL(a_root_low, sqrt_stat.done, root_sq <= ChkW'(var_r), "root too large")
  `CSU_ASSERT_IMPL(a_root_high, sqrt_stat.done, root_up_sq > ChkW'(var_r), "root too small")
  `CSU_ASSERT_NEXT(a_job_starts_div, jq_pop, div_stat.busy && (state_r == S_DSUM), "divider idle")

endmodule
`default_nettype wire
